// ----- rtl/distance_threshold_switch_defines.svh -----
// Assertion macros used by the checker file of the distance threshold switch.
`ifndef DISTANCE_THRESHOLD_SWITCH_DEFINES_SVH
`define DISTANCE_THRESHOLD_SWITCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("distance threshold switch check failed");

// The consequent must hold in the cycle after the antecedent.
`define DTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("distance threshold switch check failed");

`endif

// ----- rtl/dts_pkg.sv -----
// Types and constants shared by the distance threshold switch modules.
`default_nettype none

package dts_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned ADC_W      = 12;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned POT_W      = 11;
  localparam int unsigned MARGIN_W   = 8;
  localparam int unsigned TICKS_W    = 10;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DIST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADC  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_MARGIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MARGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_SHORT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_MID     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_LONG    = 3'd7;

  // Configuration reset values.
  localparam logic [MARGIN_W-1:0] RST_SET_MARGIN     = 8'd15;
  localparam logic [MARGIN_W-1:0] RST_RELEASE_MARGIN = 8'd5;
  localparam logic [THR_W-1:0]    RST_MIN_DISTANCE   = 12'd30;
  localparam logic [TICKS_W-1:0]  RST_HOLD_TICKS     = 10'd200;
  localparam logic [TICKS_W-1:0]  RST_REFRESH_TICKS  = 10'd100;
  localparam logic [THR_W-1:0]    RST_THRESH_SHORT   = 12'd200;
  localparam logic [THR_W-1:0]    RST_THRESH_MID     = 12'd300;
  localparam logic [THR_W-1:0]    RST_THRESH_LONG    = 12'd500;

  // Pot threshold scaling: avg * POT_SCALE >> POT_SHIFT, floored at POT_MIN.
  localparam int unsigned POT_SCALE   = 1200;
  localparam int unsigned POT_SCALE_W = 11;
  localparam int unsigned POT_SHIFT   = 12;
  localparam int unsigned POT_MIN     = 30;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DIST_W-1:0] distance;
    logic              switch_a;
    logic              switch_b;
  } item_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ----- rtl/dts_ring.sv -----
// Sample ring of the potentiometer averager with its running sum.
`default_nettype none

module dts_ring
  import dts_pkg::*;
#(
  parameter int unsigned AVG_SAMPLES = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ADC_W-1:0] sample_i,
  output logic [SUM_W-1:0] sum_o
);

  localparam int unsigned PtrW = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(AVG_SAMPLES - 1);

  logic [ADC_W-1:0] ring_q [AVG_SAMPLES];
  logic [PtrW-1:0]  ptr_q;
  logic [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVG_SAMPLES; i++) begin
        ring_q[i] <= '0;
      end
      ptr_q <= '0;
      sum_q <= '0;
    end else if (push_i) begin
      // The oldest sample leaves the sum as the new one enters.
      ring_q[ptr_q] <= sample_i;
      sum_q         <= sum_q - SUM_W'(ring_q[ptr_q]) + SUM_W'(sample_i);
      ptr_q         <= (ptr_q == PtrLast) ? '0 : ptr_q + 1'b1;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ----- rtl/dts_pot_calc.sv -----
// Pipelined pot threshold calculation: sum / AVG_SAMPLES, scaled and clamped.
`default_nettype none

module dts_pot_calc
  import dts_pkg::*;
#(
  parameter int unsigned AVG_SAMPLES = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  item_t            item_i,
  input  logic [SUM_W-1:0] sum_i,
  output logic             valid_o,
  output item_t            item_o,
  output logic [POT_W-1:0] pot_o
);

  // A reciprocal with four guard bits leaves the quotient at most one short.
  localparam int unsigned RecipShift = SUM_W + 4;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned ProdW      = SUM_W + RecipW;
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << RecipShift) / AVG_SAMPLES);
  localparam logic [SUM_W-1:0]  Divisor = SUM_W'(AVG_SAMPLES);
  localparam int unsigned ScaleW = SUM_W + POT_SCALE_W;
  localparam int unsigned VW     = ScaleW - POT_SHIFT;

  logic             s2_valid_q, s3_valid_q, s4_valid_q;
  item_t            s2_item_q, s3_item_q, s4_item_q;
  logic [SUM_W-1:0] s2_sum_q, s2_quot_q;
  logic [SUM_W-1:0] s3_avg_q;
  logic [POT_W-1:0] s4_pot_q;

  logic [ProdW-1:0]  recip_prod;
  logic [SUM_W-1:0]  quot_back, quot_rem, avg_d;
  logic [ScaleW-1:0] scaled;
  logic [VW-1:0]     pot_raw, pot_clamped;

  always_comb begin
    recip_prod = ProdW'(sum_i) * ProdW'(Recip);
  end

  always_comb begin
    quot_back = s2_quot_q * Divisor;
    quot_rem  = s2_sum_q - quot_back;
    avg_d     = (quot_rem >= Divisor) ? s2_quot_q + 1'b1 : s2_quot_q;
  end

  always_comb begin
    scaled      = ScaleW'(s3_avg_q) * ScaleW'(POT_SCALE);
    pot_raw     = scaled[ScaleW-1:POT_SHIFT];
    pot_clamped = (pot_raw < VW'(POT_MIN)) ? VW'(POT_MIN) : pot_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= valid_i;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_item_q <= item_i;
      s2_sum_q  <= sum_i;
      s2_quot_q <= recip_prod[RecipShift +: SUM_W];
      s3_item_q <= s2_item_q;
      s3_avg_q  <= avg_d;
      s4_item_q <= s3_item_q;
      s4_pot_q  <= pot_clamped[POT_W-1:0];
    end
  end

  assign valid_o = s4_valid_q;
  assign item_o  = s4_item_q;
  assign pot_o   = s4_pot_q;

endmodule

`default_nettype wire

// ----- rtl/dts_core.sv -----
// Configuration registers, timers, threshold selection and detect decision.
`default_nettype none

module dts_core
  import dts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  item_t            item_i,
  input  logic [POT_W-1:0] pot_cand_i,
  input  cfg_wr_t          cfg_i,
  output logic             out_valid_o,
  output logic             detect_o,
  output logic [THR_W-1:0] threshold_cm_o,
  output logic [POT_W-1:0] pot_cm_o,
  output logic             hold_active_o
);

  logic [MARGIN_W-1:0] set_margin_q, release_margin_q;
  logic [THR_W-1:0]    min_distance_q, thresh_short_q, thresh_mid_q, thresh_long_q;
  logic [TICKS_W-1:0]  hold_ticks_q, refresh_ticks_q;

  logic [DIST_W-1:0]  last_dist_q, last_dist_d;
  logic               detect_q, detect_d;
  logic [TICKS_W-1:0] hold_q, hold_d, hold_tick;
  logic [TICKS_W-1:0] refresh_q, refresh_d, refresh_tick;
  logic [POT_W-1:0]   pot_q, pot_d;
  logic [THR_W-1:0]   thr_q, thr_d;
  logic               out_valid_q;

  logic             is_tick;
  logic [THR_W:0]   set_level, release_level;
  logic             set_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_margin_q     <= RST_SET_MARGIN;
      release_margin_q <= RST_RELEASE_MARGIN;
      min_distance_q   <= RST_MIN_DISTANCE;
      hold_ticks_q     <= RST_HOLD_TICKS;
      refresh_ticks_q  <= RST_REFRESH_TICKS;
      thresh_short_q   <= RST_THRESH_SHORT;
      thresh_mid_q     <= RST_THRESH_MID;
      thresh_long_q    <= RST_THRESH_LONG;
    end else if (cfg_i.we) begin
      case (cfg_i.index)
        CFG_SET_MARGIN:     set_margin_q     <= cfg_i.data[MARGIN_W-1:0];
        CFG_RELEASE_MARGIN: release_margin_q <= cfg_i.data[MARGIN_W-1:0];
        CFG_MIN_DISTANCE:   min_distance_q   <= cfg_i.data[THR_W-1:0];
        CFG_HOLD_TICKS:     hold_ticks_q     <= cfg_i.data[TICKS_W-1:0];
        CFG_REFRESH_TICKS:  refresh_ticks_q  <= cfg_i.data[TICKS_W-1:0];
        CFG_THRESH_SHORT:   thresh_short_q   <= cfg_i.data[THR_W-1:0];
        CFG_THRESH_MID:     thresh_mid_q     <= cfg_i.data[THR_W-1:0];
        CFG_THRESH_LONG:    thresh_long_q    <= cfg_i.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    is_tick      = (item_i.cmd == CMD_TICK);
    refresh_tick = (is_tick && refresh_q != '0) ? refresh_q - 1'b1 : refresh_q;
    hold_tick    = (is_tick && hold_q != '0) ? hold_q - 1'b1 : hold_q;
    last_dist_d  = (item_i.cmd == CMD_DIST) ? item_i.distance : last_dist_q;

    // An idle refresh timer takes the freshly computed pot value.
    if (refresh_tick == '0) begin
      pot_d     = pot_cand_i;
      refresh_d = refresh_ticks_q;
    end else begin
      pot_d     = pot_q;
      refresh_d = refresh_tick;
    end

    case ({item_i.switch_a, item_i.switch_b})
      2'b11:   thr_d = THR_W'(pot_d);
      2'b10:   thr_d = thresh_short_q;
      2'b01:   thr_d = thresh_mid_q;
      default: thr_d = thresh_long_q;
    endcase

    set_level     = (THR_W + 1)'(thr_d) + (THR_W + 1)'(set_margin_q);
    release_level = (THR_W + 1)'(thr_d) + (THR_W + 1)'(release_margin_q);
    set_hit       = (last_dist_d > DIST_W'(min_distance_q)) &&
                    (last_dist_d > DIST_W'(set_level));

    detect_d = detect_q;
    hold_d   = hold_tick;
    if (set_hit) begin
      detect_d = 1'b1;
      hold_d   = hold_ticks_q;
    end else if (hold_tick == '0 && detect_q &&
                 last_dist_d < DIST_W'(release_level)) begin
      detect_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dist_q <= '0;
      detect_q    <= 1'b0;
      hold_q      <= '0;
      refresh_q   <= '0;
      pot_q       <= '0;
      thr_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= valid_i;
      if (valid_i) begin
        last_dist_q <= last_dist_d;
        detect_q    <= detect_d;
        hold_q      <= hold_d;
        refresh_q   <= refresh_d;
        pot_q       <= pot_d;
        thr_q       <= thr_d;
      end
    end
  end

  // The state after the last item is also the result being offered.
  assign out_valid_o    = out_valid_q;
  assign detect_o       = detect_q;
  assign threshold_cm_o = thr_q;
  assign pot_cm_o       = pot_q;
  assign hold_active_o  = (hold_q != '0);

endmodule

`default_nettype wire

// ----- rtl/distance_threshold_switch.sv -----
// Throughput: one item per cycle; the input, three pot calculation stages and
// the result register move together and stall only while a result waits.
// Reset: asynchronous, clears the sample ring, its sum, timers, detect flag and
// pot value, and loads the configuration defaults; no clearing pass follows.
`default_nettype none

module distance_threshold_switch
  import dts_pkg::*;
#(
  parameter int unsigned AVG_SAMPLES = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [DIST_W-1:0]     distance_i,
  input  logic [ADC_W-1:0]      adc_sample_i,
  input  logic                  switch_a_i,
  input  logic                  switch_b_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  detect_o,
  output logic [THR_W-1:0]      threshold_cm_o,
  output logic [POT_W-1:0]      pot_cm_o,
  output logic                  hold_active_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic             advance;
  logic             accept;
  item_t            in_item;
  logic             s1_valid_q;
  item_t            s1_item_q;
  logic [SUM_W-1:0] ring_sum;
  logic             s4_valid;
  item_t            s4_item;
  logic [POT_W-1:0] s4_pot;
  cfg_wr_t          cfg_wr;
  logic             core_out_valid;

  assign advance    = !core_out_valid || out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;

  assign in_item.cmd      = cmd_i;
  assign in_item.distance = distance_i;
  assign in_item.switch_a = switch_a_i;
  assign in_item.switch_b = switch_b_i;

  assign cfg_wr.we    = cfg_we_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_item_q <= in_item;
    end
  end

  // The ring sum is updated on the transfer, so it belongs to the item in stage one.
  dts_ring #(
    .AVG_SAMPLES(AVG_SAMPLES)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && (cmd_i == CMD_ADC)),
    .sample_i(adc_sample_i),
    .sum_o   (ring_sum)
  );

  dts_pot_calc #(
    .AVG_SAMPLES(AVG_SAMPLES)
  ) u_pot_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .valid_i(s1_valid_q),
    .item_i (s1_item_q),
    .sum_i  (ring_sum),
    .valid_o(s4_valid),
    .item_o (s4_item),
    .pot_o  (s4_pot)
  );

  dts_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .valid_i       (s4_valid),
    .item_i        (s4_item),
    .pot_cand_i    (s4_pot),
    .cfg_i         (cfg_wr),
    .out_valid_o   (core_out_valid),
    .detect_o      (detect_o),
    .threshold_cm_o(threshold_cm_o),
    .pot_cm_o      (pot_cm_o),
    .hold_active_o (hold_active_o)
  );

  assign out_valid_o = core_out_valid;

endmodule

`default_nettype wire

// ----- rtl/dts_checker.sv -----
// Port-level checker for the distance threshold switch, bound to its top level.
`default_nettype none
`include "distance_threshold_switch_defines.svh"

module dts_checker
  import dts_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  detect_o,
  input logic [THR_W-1:0]      threshold_cm_o,
  input logic [POT_W-1:0]      pot_cm_o,
  input logic                  hold_active_o
);

  // A stalled result keeps its value.
  `DTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(detect_o) && $stable(threshold_cm_o) && $stable(pot_cm_o) && $stable(hold_active_o))

  // Input transfers are refused only while a result waits.
  `DTS_ASSERT_NOW(a_ready_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // The hold timer only runs after a set, and release waits for it.
  `DTS_ASSERT_NOW(a_hold_detect, clk_i, rst_ni, out_valid_o && hold_active_o, detect_o)

  // Once computed, the pot threshold is never below its floor.
  `DTS_ASSERT_NOW(a_pot_floor, clk_i, rst_ni, out_valid_o && (pot_cm_o != '0), pot_cm_o >= POT_W'(POT_MIN))

endmodule

bind distance_threshold_switch dts_checker u_dts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .detect_o      (detect_o),
  .threshold_cm_o(threshold_cm_o),
  .pot_cm_o      (pot_cm_o),
  .hold_active_o (hold_active_o)
);

`default_nettype wire
